// ----- hw/rtl/bmpd_pkg.sv -----
package bmpd_pkg;

  localparam int MaxWidth = 4096;
  localparam int MaxHeight = 4096;
  localparam int PaletteDepth = 256;
  localparam int PalAddrW = $clog2(PaletteDepth);
  localparam logic [15:0] Magic = 16'h4d42;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_PIXELS,
    PH_DONE,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_HDR_ERR = 2'd1,
    KIND_FMT_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_4 = 2'd1,
    DEPTH_8 = 2'd2,
    DEPTH_24 = 2'd3
  } depth_t;

  // pixel job handed from byte parser to emitter
  typedef struct packed {
    logic [7:0] pix_byte;
    logic [3:0] count;
    depth_t depth;
    logic [12:0] col;
    logic [12:0] row;
    logic [12:0] width;
    logic [12:0] height;
    logic [23:0] rgb;
    logic last_byte_res;
  } job_t;

endpackage

// ----- hw/rtl/bmpd_ram.sv -----
module bmpd_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bitmap_pixel_stream_decoder.sv -----
// results: palette bytes, and header bytes that flag no error, give no result;
// an error result and a 24-bit pixel pass the job, stage and output registers
// palette pixels: one per cycle through the palette ram read port while the output
// is not stalled; a byte of 1-bit pixels gives up to 8, 4-bit up to 2, 8-bit 1
// reset: synchronous, clears parse state; the palette ram holds no reset value
module bitmap_pixel_stream_decoder
  import bmpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [11:0] pixel_x,
  output logic [11:0] pixel_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last_of_run,
  output logic        image_done
);

  phase_t phase, ph;
  logic [5:0] hcnt, hc;
  logic herr, he;
  logic [12:0] img_w, img_h, w_n, h_n;
  depth_t dcode, d_n;
  logic [9:0] pcnt;
  logic [12:0] col, row, col_n, row_n;
  logic [1:0] rphase, rp_n;
  logic [15:0] part, part_n;
  logic [1:0] tphase, tp_n;
  logic [31:0] hsh, hs_n;

  // emitter: job register, then ram read stage, then output register
  logic job_v;
  job_t job;
  logic [3:0] k;
  logic s_v, s_pal, s_last, s_done;
  logic [1:0] s_kind;
  logic [11:0] s_x, s_y;
  logic [23:0] s_rgb;
  logic [23:0] ram_q;
  logic ram_we;
  logic [PalAddrW-1:0] ram_wa, ram_ra;
  logic [23:0] pal_w;
  logic s_fresh;
  logic [23:0] pal_hold;

  logic o_v;
  logic stage_adv, job_take, take;
  logic new_job;
  job_t nj;
  logic [3:0] n_pix;

  assign stage_adv = !o_v || out_ready || !s_v;
  assign job_take = job_v && stage_adv && (k + 4'd1 == job.count);
  assign in_ready = !job_v || job_take;
  assign take = in_valid && in_ready;

  // parser
  logic [31:0] sh;
  logic [15:0] bc;
  logic [3:0] ppb;
  logic [12:0] rem;
  logic [9:0] pal_bytes;
  always_comb begin
    ph = phase; hc = hcnt; he = herr; w_n = img_w; h_n = img_h; d_n = dcode;
    col_n = col; row_n = row; rp_n = rphase; part_n = part; tp_n = tphase;
    hs_n = hsh; new_job = 1'b0; nj = '0; n_pix = '0;
    ram_we = 1'b0; ram_wa = '0; pal_w = '0;
    sh = '0; bc = '0; ppb = '0; rem = '0; pal_bytes = '0;
    if (start_of_image) begin
      ph = PH_HEADER; hc = '0; he = 1'b0; hs_n = '0;
    end
    nj.depth = d_n; nj.col = col; nj.row = row; nj.width = img_w;
    nj.height = img_h; nj.pix_byte = data_byte; nj.last_byte_res = 1'b1;
    case (ph)
      PH_HEADER: begin
        sh = {data_byte, hs_n[31:8]};
        hs_n = sh;
        bc = sh[31:16];
        if (hc == 6'd1 && sh[31:16] != Magic) he = 1'b1;
        if (hc == 6'd9 && sh != '0) he = 1'b1;
        if (hc == 6'd13 && he) begin
          new_job = 1'b1; nj.count = 4'd1; nj.rgb = {22'd0, KIND_HDR_ERR};
          nj.depth = DEPTH_24; ph = PH_HALT;
        end else if (hc == 6'd21) begin
          if (sh < 32'd1 || sh > 32'(MaxWidth)) he = 1'b1;
          else w_n = sh[12:0];
        end else if (hc == 6'd25) begin
          if (sh < 32'd1 || sh > 32'(MaxHeight)) he = 1'b1;
          else h_n = sh[12:0];
        end else if (hc == 6'd29) begin
          case (bc)
            16'd1: d_n = DEPTH_1;
            16'd4: d_n = DEPTH_4;
            16'd8: d_n = DEPTH_8;
            16'd24: d_n = DEPTH_24;
            default: he = 1'b1;
          endcase
        end else if (hc == 6'd53) begin
          if (!he && ((dcode == DEPTH_8 && PaletteDepth < 256) ||
              (dcode == DEPTH_4 && PaletteDepth < 16))) he = 1'b1;
          if (he) begin
            new_job = 1'b1; nj.count = 4'd1; nj.rgb = {22'd0, KIND_FMT_ERR};
            nj.depth = DEPTH_24; ph = PH_HALT;
          end else if (dcode == DEPTH_24) begin
            ph = PH_PIXELS; col_n = '0; row_n = '0; rp_n = '0; part_n = '0;
            tp_n = '0;
          end else ph = PH_PALETTE;
        end
        if (hc < 6'd53) hc = hc + 6'd1;
      end
      PH_PALETTE: begin
        ram_wa = PalAddrW'(pcnt[9:2]);
        case (pcnt[1:0])
          2'd0: pal_w = {16'd0, data_byte};
          2'd1: pal_w = {8'd0, data_byte, part[7:0]};
          default: pal_w = {data_byte, part};
        endcase
        ram_we = (pcnt[1:0] != 2'd3) && ({2'd0, pcnt[9:2]} < 10'(PaletteDepth));
        part_n = pal_w[15:0];
        case (dcode)
          DEPTH_1: pal_bytes = 10'd8;
          DEPTH_4: pal_bytes = 10'd64;
          default: pal_bytes = 10'd0;
        endcase
        if (pcnt + 10'd1 == pal_bytes) begin
          ph = PH_PIXELS; col_n = '0; row_n = '0; rp_n = '0; part_n = '0;
          tp_n = '0;
        end
      end
      PH_PIXELS: begin
        if (col < img_w) begin
          if (dcode == DEPTH_24) begin
            if (tphase == 2'd0) begin
              part_n = {8'd0, data_byte}; tp_n = 2'd1;
            end else if (tphase == 2'd1) begin
              part_n = {data_byte, part[7:0]}; tp_n = 2'd2;
            end else begin
              new_job = 1'b1; nj.count = 4'd1;
              nj.rgb = {data_byte, part}; tp_n = 2'd0; col_n = col + 13'd1;
            end
          end else begin
            case (dcode)
              DEPTH_1: ppb = 4'd8;
              DEPTH_4: ppb = 4'd2;
              default: ppb = 4'd1;
            endcase
            rem = img_w - col;
            n_pix = (rem < 13'(ppb)) ? rem[3:0] : ppb;
            new_job = 1'b1; nj.count = n_pix; col_n = col + 13'(n_pix);
          end
          rp_n = rphase + 2'd1;
          if (col_n >= img_w && tp_n == 2'd0 && rp_n == 2'd0) begin
            col_n = '0; row_n = row + 13'd1;
            if (row_n >= img_h) ph = PH_DONE;
          end
        end else begin
          rp_n = rphase + 2'd1;
          if (rp_n == 2'd0) begin
            col_n = '0; row_n = row + 13'd1;
            if (row_n >= img_h) ph = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; hcnt <= '0; herr <= 1'b0; img_w <= '0; img_h <= '0;
      dcode <= DEPTH_1; pcnt <= '0; col <= '0; row <= '0; rphase <= '0;
      part <= '0; tphase <= '0; hsh <= '0;
    end else if (take) begin
      phase <= ph; hcnt <= hc; herr <= he; img_w <= w_n; img_h <= h_n;
      dcode <= d_n; col <= col_n; row <= row_n; rphase <= rp_n;
      part <= part_n; tphase <= tp_n; hsh <= hs_n;
      pcnt <= (phase == PH_PALETTE && !start_of_image) ? pcnt + 10'd1 : '0;
    end
  end

  // emitter
  logic [12:0] e_col;
  logic [7:0] idx;
  always_comb begin
    e_col = job.col + 13'(k);
    case (job.depth)
      DEPTH_1: idx = {7'd0, job.pix_byte[3'd7 - k[2:0]]};
      DEPTH_4: idx = k[0] ? {4'd0, job.pix_byte[3:0]} : {4'd0, job.pix_byte[7:4]};
      default: idx = job.pix_byte;
    endcase
    ram_ra = PalAddrW'(idx);
  end

  logic job_is_err;
  always_ff @(posedge clk) begin
    if (rst) begin
      job_v <= 1'b0; k <= '0; s_v <= 1'b0; o_v <= 1'b0;
    end else begin
      if (stage_adv) begin
        s_v <= job_v;
        if (job_take || !job_v) k <= '0;
        else k <= k + 4'd1;
      end
      if (take) job_v <= new_job;
      else if (job_take) job_v <= 1'b0;
      if (!o_v || out_ready) o_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take && new_job) begin
      job <= nj;
      job_is_err <= (ph == PH_HALT);
    end
    if (stage_adv) begin
      s_pal <= job.depth != DEPTH_24;
      s_last <= (k + 4'd1 == job.count);
      s_kind <= job_is_err ? job.rgb[1:0] : KIND_PIXEL;
      s_x <= job_is_err ? '0 : e_col[11:0];
      s_y <= job_is_err ? '0 : 12'(job.height - 13'd1 - job.row);
      s_rgb <= job_is_err ? '0 : job.rgb;
      s_done <= !job_is_err && (job.row + 13'd1 == job.height) &&
                (e_col + 13'd1 == job.width);
    end
    if (!o_v || out_ready) begin
      kind <= s_kind; pixel_x <= s_x; pixel_y <= s_y;
      {red, green, blue} <= s_pal ? (s_fresh ? ram_q : pal_hold) : s_rgb;
      last_of_run <= s_last; image_done <= s_done;
    end
  end

  // palette ram read data is only valid the cycle after the stage moves, so hold it
  always_ff @(posedge clk) begin
    if (rst) begin
      s_fresh <= 1'b0;
    end else begin
      s_fresh <= stage_adv;
    end
    if (s_fresh) pal_hold <= ram_q;
  end

  bmpd_ram #(.Width(24), .Depth(PaletteDepth)) u_pal (
    .clk(clk), .we(take && ram_we), .waddr(ram_wa), .wdata(pal_w),
    .raddr(ram_ra), .rdata(ram_q)
  );

  assign out_valid = o_v;

endmodule
